// ----- hdl/wrp_pkg.sv -----
package wrp_pkg;

	// default sizes, handed to the top level parameters
	localparam int DEF_MAX_MESH_WIDTH  = 64;
	localparam int DEF_MAX_MESH_HEIGHT = 64;
	localparam int DEF_TABLE_LAST      = 512;

	localparam int MESH_MIN = 8;

	// refraction arithmetic
	localparam logic [31:0] WAVE_BIAS = 32'h0001_0000;
	localparam int WAVE_SHIFT = 8;
	localparam int REFR_SHIFT = 3;
	localparam int TEX_SHIFT  = 16;

	// field widths fixed by the interface
	localparam int QUO_W  = 10;
	localparam int STR_W  = 8;
	localparam int IDX_W  = 10;
	localparam int REG_AW = 4;

	// operation kinds
	localparam logic [1:0] KIND_DROP  = 2'd0;
	localparam logic [1:0] KIND_STEP  = 2'd1;
	localparam logic [1:0] KIND_LOAD  = 2'd2;
	localparam logic [1:0] KIND_QUERY = 2'd3;

	// register indexes
	localparam logic [1:0] REG_MESH_WIDTH    = 2'd0;
	localparam logic [1:0] REG_MESH_HEIGHT   = 2'd1;
	localparam logic [1:0] REG_DROP_RADIUS   = 2'd2;
	localparam logic [1:0] REG_DROP_STRENGTH = 2'd3;

	// register reset values
	localparam logic [6:0] RST_MESH_WIDTH    = 7'd64;
	localparam logic [6:0] RST_MESH_HEIGHT   = 7'd64;
	localparam logic [1:0] RST_DROP_RADIUS   = 2'd2;
	localparam logic [7:0] RST_DROP_STRENGTH = 8'd1;

	typedef struct packed {
		logic             go;
		logic [QUO_W-1:0] num;
		logic [STR_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
	} div_rsp_t;

	// floor(sqrt(k << 16)) for the disc depths k = 0..9
	function automatic logic [QUO_W-1:0] disc_depth(input logic [3:0] k);
		logic [QUO_W-1:0] v;
		unique case (k)
			4'd0: v = 10'd0;
			4'd1: v = 10'd256;
			4'd2: v = 10'd362;
			4'd3: v = 10'd443;
			4'd4: v = 10'd512;
			4'd5: v = 10'd572;
			4'd6: v = 10'd627;
			4'd7: v = 10'd677;
			4'd8: v = 10'd724;
			4'd9: v = 10'd768;
			default: v = 10'd0;
		endcase
		return v;
	endfunction

endpackage

// ----- hdl/wrp_ram.sv -----
module wrp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/wrp_div.sv -----
module wrp_div import wrp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CW = $clog2(QUO_W + 1);

	logic             run_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [QUO_W-1:0] num_q;
	logic [STR_W-1:0] den_q;
	logic [STR_W-1:0] rem_q;
	logic [STR_W:0]   trial;
	logic             fits;

	// restoring division, one quotient bit a cycle
	assign trial = {rem_q, num_q[QUO_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(QUO_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= fits ? STR_W'(trial - {1'b0, den_q}) : trial[STR_W-1:0];
			num_q <= {num_q[QUO_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = num_q;

endmodule

// ----- hdl/water_ripple_heightfield_unit.sv -----
// channel   | ports                                              | transaction
// ----------+----------------------------------------------------+-----------------------------
// command   | start, busy, kind, drop_col, drop_row, cell_col,   | start high while busy low
//           | cell_row, table_index, table_value                 |
// result    | done, tex_u, tex_v, slope_down, height             | done high for one cycle
// config    | psel, penable, pwrite, paddr, pwdata, prdata,      | access phase with pwrite,
//           | pready                                             | pready tied high
//
// step: each interior cell is worked through the single read port of the current map
// drop: the shared divider dominates the work on each disc pair;
//   query: three map reads, two table reads, one shared multiplier
// after reset both maps are swept to zero, one word a cycle, over all (MAX_MESH_WIDTH+2)*
//   (MAX_MESH_HEIGHT+2) words (4356 by default); busy stays high, config writes still land
// busy is high for the whole of a transaction; the result cannot be stalled
module water_ripple_heightfield_unit import wrp_pkg::*; #(
	parameter int MAX_MESH_WIDTH  = DEF_MAX_MESH_WIDTH,
	parameter int MAX_MESH_HEIGHT = DEF_MAX_MESH_HEIGHT,
	parameter int TABLE_LAST      = DEF_TABLE_LAST
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// config port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [REG_AW-1:0]        paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	// command
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               kind,
	input  logic signed [15:0]       drop_col,
	input  logic signed [15:0]       drop_row,
	input  logic [5:0]               cell_col,
	input  logic [5:0]               cell_row,
	input  logic [IDX_W-1:0]         table_index,
	input  logic signed [31:0]       table_value,
	// result
	output logic                     done,
	output logic [5:0]               tex_u,
	output logic [5:0]               tex_v,
	output logic signed [31:0]       slope_down,
	output logic signed [31:0]       height
);

	localparam int MAP_DEPTH = (MAX_MESH_WIDTH + 2) * (MAX_MESH_HEIGHT + 2);
	localparam int MAW       = $clog2(MAP_DEPTH);
	localparam int TAB_DEPTH = TABLE_LAST + 1;
	localparam int TAW       = $clog2(TAB_DEPTH);
	localparam int IXW       = (TAW > IDX_W) ? TAW : IDX_W;

	// sequencer states
	localparam logic [2:0] ST_CLR   = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_DPAIR = 3'd2;
	localparam logic [2:0] ST_DDIV  = 3'd3;
	localparam logic [2:0] ST_DWR   = 3'd4;
	localparam logic [2:0] ST_STEP  = 3'd5;
	localparam logic [2:0] ST_QRY   = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	// ---------------------------------------------------------------- config registers
	logic [6:0] mw_q;
	logic [6:0] mh_q;
	logic [1:0] rad_q;
	logic [7:0] str_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mw_q  <= RST_MESH_WIDTH;
			mh_q  <= RST_MESH_HEIGHT;
			rad_q <= RST_DROP_RADIUS;
			str_q <= RST_DROP_STRENGTH;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_MESH_WIDTH:    mw_q  <= pwdata[6:0];
				REG_MESH_HEIGHT:   mh_q  <= pwdata[6:0];
				REG_DROP_RADIUS:   rad_q <= pwdata[1:0];
				REG_DROP_STRENGTH: str_q <= pwdata[7:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_MESH_WIDTH:    prdata = {25'd0, mw_q};
			REG_MESH_HEIGHT:   prdata = {25'd0, mh_q};
			REG_DROP_RADIUS:   prdata = {30'd0, rad_q};
			REG_DROP_STRENGTH: prdata = {24'd0, str_q};
		endcase
	end

	assign pready = 1'b1;

	// ---------------------------------------------------------------- helpers
	// saturate a mesh size register to [8, max]
	function automatic logic [6:0] eff_size(input logic [6:0] v, input int mx);
		logic [6:0] r;
		if (v < 7'(MESH_MIN)) begin
			r = 7'(MESH_MIN);
		end else if ({2'b0, v} > 9'(mx)) begin
			r = 7'(mx);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// word address of interior cell (col, row) with row stride s
	function automatic logic [17:0] cell_addr(input logic [7:0] row, input logic [7:0] col,
			input logic [7:0] s);
		logic [17:0] p;
		p = ({10'd0, row} + 18'd1) * {10'd0, s};
		return p + {10'd0, col} + 18'd1;
	endfunction

	// table index of a height difference: magnitude saturated to the last entry
	function automatic logic [TAW-1:0] tab_index(input logic [31:0] d);
		logic [31:0] m;
		m = d[31] ? 32'd0 - d : d;
		return (m > 32'(TABLE_LAST)) ? TAW'(TABLE_LAST) : m[TAW-1:0];
	endfunction

	// refracted texel coordinate from the scaled product, clamped to [0, lim-1]
	function automatic logic [5:0] tex_of(input logic [31:0] prod, input logic neg,
			input logic [5:0] c, input logic [6:0] lim);
		logic [31:0]        r;
		logic [31:0]        sr;
		logic signed [17:0] u;
		logic [5:0]         t;
		r  = 32'($signed(prod) >>> REFR_SHIFT);
		sr = neg ? 32'd0 - r : r;
		u  = $signed({12'd0, c}) + 18'sd1 + $signed({{2{sr[31]}}, sr[31:TEX_SHIFT]});
		if (u < 18'sd0) begin
			t = '0;
		end else if (u >= $signed({11'd0, lim})) begin
			t = 6'(lim - 7'd1);
		end else begin
			t = u[5:0];
		end
		return t;
	endfunction

	logic [6:0] w_eff;
	logic [6:0] h_eff;
	logic [7:0] s_w;
	logic [MAW-1:0] s_a;

	assign w_eff = eff_size(mw_q, MAX_MESH_WIDTH);
	assign h_eff = eff_size(mh_q, MAX_MESH_HEIGHT);
	assign s_w   = {1'b0, w_eff} + 8'd2;
	assign s_a   = MAW'(s_w);

	// ---------------------------------------------------------------- state
	logic [2:0]     state_q;
	logic [MAW-1:0] clr_q;
	logic           sel_q;
	logic           done_q;
	logic [2:0]     ph_q;
	logic [MAW-1:0] base_q;
	logic [6:0]     scol_q;
	logic [6:0]     srow_q;
	logic [1:0]     a_q;
	logic [1:0]     b_q;
	logic [1:0]     wsub_q;

	// payload
	logic [7:0]  x_q;
	logic [7:0]  y_q;
	logic [31:0] val_q;
	logic [31:0] sum_q;
	logic [31:0] own_q;
	logic [31:0] d_q;
	logic [31:0] h0_q;
	logic [31:0] dx_q;
	logic [31:0] dy_q;
	logic [31:0] w_q;
	logic [31:0] prod_q;
	logic [5:0]  qcol_q;
	logic [5:0]  qrow_q;
	logic [5:0]  tex_u_q;
	logic [5:0]  tex_v_q;
	logic [31:0] slope_q;
	logic [31:0] height_q;

	logic accept;
	assign busy   = state_q != ST_IDLE;
	assign accept = start && !busy;

	// ---------------------------------------------------------------- drop setup
	logic signed [17:0] r18;
	logic signed [17:0] wd18;
	logic signed [17:0] hd18;
	logic signed [17:0] xc;
	logic signed [17:0] yc;
	logic signed [17:0] xm;

	assign r18  = $signed({16'd0, rad_q});
	assign wd18 = $signed({11'd0, w_eff});
	assign hd18 = $signed({11'd0, h_eff});

	// clamp into the disc-safe interior, then mirror the column
	always_comb begin
		xc = 18'(drop_col);
		yc = 18'(drop_row);
		if (xc < r18) begin
			xc = r18;
		end
		if (yc < r18) begin
			yc = r18;
		end
		if (xc >= wd18 - r18) begin
			xc = wd18 - r18 - 18'sd1;
		end
		if (yc >= hd18 - r18) begin
			yc = hd18 - r18 - 18'sd1;
		end
		xm = wd18 - xc;
	end

	// disc pair (a, b) inside r and its depth index k = r^2 - a^2 - b^2
	logic [3:0] r2;
	logic [3:0] ab2;
	logic       in_disc;
	logic [1:0] rad_m1;
	logic       pair_last;

	assign r2        = {2'd0, rad_q} * {2'd0, rad_q};
	assign ab2       = {2'd0, a_q} * {2'd0, a_q} + {2'd0, b_q} * {2'd0, b_q};
	assign in_disc   = ab2 < r2;
	assign rad_m1    = rad_q - 2'd1;
	assign pair_last = (a_q == rad_m1) && (b_q == rad_m1);

	div_req_t div_req;
	div_rsp_t div_rsp;

	assign div_req.go  = (state_q == ST_DPAIR) && in_disc;
	assign div_req.num = disc_depth(r2 - ab2);
	assign div_req.den = (str_q == 8'd0) ? 8'd1 : str_q;

	wrp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// four mirrored cells of a disc pair
	logic [7:0]  dcol;
	logic [7:0]  drow;
	logic [17:0] daddr;

	assign dcol  = wsub_q[1] ? x_q - {6'd0, a_q} : x_q + {6'd0, a_q};
	assign drow  = wsub_q[0] ? y_q + {6'd0, b_q} : y_q - {6'd0, b_q};
	assign daddr = cell_addr(drow, dcol, s_w);

	// query cell, saturated into the mesh
	logic [5:0]  qcol;
	logic [5:0]  qrow;
	logic [17:0] qaddr;

	assign qcol  = ({1'b0, cell_col} >= w_eff) ? 6'(w_eff - 7'd1) : cell_col;
	assign qrow  = ({1'b0, cell_row} >= h_eff) ? 6'(h_eff - 7'd1) : cell_row;
	assign qaddr = cell_addr({2'd0, qrow}, {2'd0, qcol}, s_w);

	logic step_last;
	assign step_last = (scol_q == w_eff - 7'd1) && (srow_q == h_eff - 7'd1);

	// ---------------------------------------------------------------- map and table ports
	logic [MAW-1:0] cur_raddr;
	logic [MAW-1:0] nxt_raddr;
	logic           cur_we;
	logic           nxt_we;
	logic [MAW-1:0] cur_waddr;
	logic [31:0]    nxt_wdata;
	logic [31:0]    cur_rd;
	logic [31:0]    nxt_rd;

	logic           m0_we;
	logic           m1_we;
	logic [MAW-1:0] m0_waddr;
	logic [MAW-1:0] m1_waddr;
	logic [31:0]    m0_wdata;
	logic [31:0]    m1_wdata;
	logic [MAW-1:0] m0_raddr;
	logic [MAW-1:0] m1_raddr;
	logic [31:0]    m0_rd;
	logic [31:0]    m1_rd;

	// read address of the current map: four neighbours in a step, three cells in a query
	always_comb begin
		cur_raddr = base_q;
		if (state_q == ST_STEP) begin
			unique case (ph_q)
				3'd0:    cur_raddr = base_q - s_a;
				3'd1:    cur_raddr = base_q + s_a;
				3'd2:    cur_raddr = base_q - MAW'(1);
				3'd3:    cur_raddr = base_q + MAW'(1);
				default: cur_raddr = base_q;
			endcase
		end else if (state_q == ST_QRY) begin
			unique case (ph_q)
				3'd1:    cur_raddr = base_q + MAW'(1);
				3'd2:    cur_raddr = base_q + s_a;
				default: cur_raddr = base_q;
			endcase
		end
	end

	assign nxt_raddr = base_q;
	assign cur_we    = state_q == ST_DWR;
	assign cur_waddr = MAW'(daddr);
	assign nxt_we    = (state_q == ST_STEP) && (ph_q == 3'd6);
	// damping: d - (d >>> 3)
	assign nxt_wdata = d_q - 32'($signed(d_q) >>> 3);

	// the select bit steers current and next onto the two physical maps
	always_comb begin
		if (state_q == ST_CLR) begin
			m0_we    = 1'b1;
			m1_we    = 1'b1;
			m0_waddr = clr_q;
			m1_waddr = clr_q;
			m0_wdata = '0;
			m1_wdata = '0;
		end else if (sel_q) begin
			m0_we    = nxt_we;
			m1_we    = cur_we;
			m0_waddr = base_q;
			m1_waddr = cur_waddr;
			m0_wdata = nxt_wdata;
			m1_wdata = val_q;
		end else begin
			m0_we    = cur_we;
			m1_we    = nxt_we;
			m0_waddr = cur_waddr;
			m1_waddr = base_q;
			m0_wdata = val_q;
			m1_wdata = nxt_wdata;
		end
	end

	assign m0_raddr = sel_q ? nxt_raddr : cur_raddr;
	assign m1_raddr = sel_q ? cur_raddr : nxt_raddr;
	assign cur_rd   = sel_q ? m1_rd : m0_rd;
	assign nxt_rd   = sel_q ? m0_rd : m1_rd;

	wrp_ram #(.WIDTH(32), .DEPTH(MAP_DEPTH)) u_map0 (
		.clk   (clk),
		.we    (m0_we),
		.waddr (m0_waddr),
		.wdata (m0_wdata),
		.raddr (m0_raddr),
		.rdata (m0_rd)
	);

	wrp_ram #(.WIDTH(32), .DEPTH(MAP_DEPTH)) u_map1 (
		.clk   (clk),
		.we    (m1_we),
		.waddr (m1_waddr),
		.wdata (m1_wdata),
		.raddr (m1_raddr),
		.rdata (m1_rd)
	);

	logic [IXW-1:0] idx_ext;
	logic           tab_we;
	logic [TAW-1:0] tab_raddr;
	logic [31:0]    tab_rd;

	assign idx_ext   = IXW'(table_index);
	// loads past the last entry are dropped
	assign tab_we    = accept && (kind == KIND_LOAD) && (idx_ext <= IXW'(TABLE_LAST));
	assign tab_raddr = (ph_q == 3'd4) ? tab_index(dx_q) : tab_index(dy_q);

	wrp_ram #(.WIDTH(32), .DEPTH(TAB_DEPTH)) u_refr (
		.clk   (clk),
		.we    (tab_we),
		.waddr (idx_ext[TAW-1:0]),
		.wdata (table_value),
		.raddr (tab_raddr),
		.rdata (tab_rd)
	);

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			sel_q   <= 1'b0;
			done_q  <= 1'b0;
			ph_q    <= '0;
			base_q  <= '0;
			scol_q  <= '0;
			srow_q  <= '0;
			a_q     <= '0;
			b_q     <= '0;
			wsub_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					if (clr_q == MAW'(MAP_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + MAW'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						ph_q <= '0;
						unique case (kind)
							KIND_DROP: begin
								a_q     <= '0;
								b_q     <= '0;
								state_q <= (rad_q == 2'd0) ? ST_DONE : ST_DPAIR;
							end
							KIND_STEP: begin
								base_q  <= s_a + MAW'(1);
								scol_q  <= '0;
								srow_q  <= '0;
								state_q <= ST_STEP;
							end
							KIND_LOAD: begin
								state_q <= ST_DONE;
							end
							KIND_QUERY: begin
								base_q  <= MAW'(qaddr);
								state_q <= ST_QRY;
							end
						endcase
					end
				end
				ST_DPAIR: begin
					if (in_disc) begin
						state_q <= ST_DDIV;
					end else if (pair_last) begin
						state_q <= ST_DONE;
					end else if (a_q == rad_m1) begin
						a_q <= '0;
						b_q <= b_q + 2'd1;
					end else begin
						a_q <= a_q + 2'd1;
					end
				end
				ST_DDIV: begin
					if (div_rsp.done) begin
						wsub_q  <= '0;
						state_q <= ST_DWR;
					end
				end
				ST_DWR: begin
					wsub_q <= wsub_q + 2'd1;
					if (wsub_q == 2'd3) begin
						if (pair_last) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_DPAIR;
							if (a_q == rad_m1) begin
								a_q <= '0;
								b_q <= b_q + 2'd1;
							end else begin
								a_q <= a_q + 2'd1;
							end
						end
					end
				end
				ST_STEP: begin
					if (ph_q == 3'd6) begin
						ph_q <= '0;
						if (step_last) begin
							sel_q   <= ~sel_q;
							state_q <= ST_DONE;
						end else if (scol_q == w_eff - 7'd1) begin
							// skip the right and left border words
							scol_q <= '0;
							srow_q <= srow_q + 7'd1;
							base_q <= base_q + MAW'(3);
						end else begin
							scol_q <= scol_q + 7'd1;
							base_q <= base_q + MAW'(1);
						end
					end else begin
						ph_q <= ph_q + 3'd1;
					end
				end
				ST_QRY: begin
					ph_q <= ph_q + 3'd1;
					if (ph_q == 3'd7) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ---------------------------------------------------------------- datapath
	logic [31:0] wave_b;
	logic [31:0] wave_s;

	assign wave_b = h0_q + WAVE_BIAS;
	assign wave_s = 32'($signed(wave_b) >>> WAVE_SHIFT);

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q      <= xm[7:0];
			y_q      <= yc[7:0];
			qcol_q   <= qcol;
			qrow_q   <= qrow;
			// non-query transactions report all zero
			tex_u_q  <= '0;
			tex_v_q  <= '0;
			slope_q  <= '0;
			height_q <= '0;
		end
		if ((state_q == ST_DDIV) && div_rsp.done) begin
			val_q <= 32'd0 - 32'(div_rsp.quo);
		end
		if (state_q == ST_STEP) begin
			unique case (ph_q)
				3'd1: begin
					sum_q <= cur_rd;
					own_q <= nxt_rd;
				end
				3'd2, 3'd3, 3'd4: sum_q <= sum_q + cur_rd;
				3'd5: d_q <= 32'($signed(sum_q) >>> 1) - own_q;
				default: ;
			endcase
		end
		if (state_q == ST_QRY) begin
			unique case (ph_q)
				3'd1: h0_q <= cur_rd;
				3'd2: dx_q <= cur_rd - h0_q;
				3'd3: begin
					dy_q <= cur_rd - h0_q;
					w_q  <= wave_s[31] ? 32'd0 : wave_s;
				end
				3'd5: prod_q <= tab_rd * w_q;
				3'd6: begin
					prod_q  <= tab_rd * w_q;
					tex_u_q <= tex_of(prod_q, dx_q[31], qcol_q, w_eff);
				end
				3'd7: begin
					tex_v_q  <= tex_of(prod_q, dy_q[31], qrow_q, h_eff);
					slope_q  <= dy_q;
					height_q <= h0_q;
				end
				default: ;
			endcase
		end
	end

	assign done       = done_q;
	assign tex_u      = tex_u_q;
	assign tex_v      = tex_v_q;
	assign slope_down = slope_q;
	assign height     = height_q;

	// ---------------------------------------------------------------- checks
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held over two cycles");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	a_both_maps: assert property (@(posedge clk) disable iff (!arst_n)
		(m0_we && m1_we) |-> (state_q == ST_CLR))
		else $error("both maps written outside the clearing sweep");

	a_sel_flip: assert property (@(posedge clk) disable iff (!arst_n)
		(sel_q != $past(sel_q)) |-> ($past(state_q) == ST_STEP))
		else $error("map select changed outside a simulation step");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

// checks the ripple unit against a behavioral copy of its two height maps,
// the select bit and the refraction table; one result is expected per command
module tb_top;
	import wrp_pkg::*;

	localparam int MAP_WORDS = (DEF_MAX_MESH_WIDTH + 2) * (DEF_MAX_MESH_HEIGHT + 2);
	localparam int WATCHDOG_LIMIT = 200000;

	typedef struct {
		logic [5:0]  u;
		logic [5:0]  v;
		logic [31:0] slope;
		logic [31:0] h;
	} ripple_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [REG_AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	logic [1:0] kind = KIND_STEP;
	logic signed [15:0] drop_col = '0, drop_row = '0;
	logic [5:0] cell_col = '0, cell_row = '0;
	logic [IDX_W-1:0] table_index = '0;
	logic signed [31:0] table_value = '0;
	logic done;
	logic [5:0] tex_u, tex_v;
	logic signed [31:0] slope_down, height;

	// shadow of the block state
	logic [31:0] shadow_map [2][MAP_WORDS];
	logic        shadow_sel;
	logic [31:0] shadow_table [DEF_TABLE_LAST + 1];
	logic [6:0]  shadow_width, shadow_height;
	logic [1:0]  shadow_radius;
	logic [7:0]  shadow_strength;

	ripple_result_t pending_results[$];
	int mismatch_count = 0;
	int idle_rate = 15;
	int stall_cycles = 0;

	water_ripple_heightfield_unit u_top (.*);

	always #1 clk = ~clk;

	// watchdog: any cycle with a command or result transaction resets it
	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles > WATCHDOG_LIMIT) begin
			$display("water_ripple_heightfield_unit: mismatch");
			$finish;
		end
	end

	// result checker, reads pre-edge values of the registered outputs
	always @(posedge clk) begin
		ripple_result_t exp_r;
		if (done) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result u=%0d v=%0d slope=%0d h=%0d",
						tex_u, tex_v, slope_down, height);
			end else begin
				exp_r = pending_results.pop_front();
				if (tex_u !== exp_r.u || tex_v !== exp_r.v ||
						slope_down !== exp_r.slope || height !== exp_r.h) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"result differs: exp u=%0d v=%0d slope=%0d h=%0d, ",
							"got u=%0d v=%0d slope=%0d h=%0d"},
							exp_r.u, exp_r.v, $signed(exp_r.slope), $signed(exp_r.h),
							tex_u, tex_v, slope_down, height);
				end
			end
		end
	end

	function automatic int eff_size(logic [6:0] v);
		if (v < MESH_MIN) return MESH_MIN;
		if (v > 64) return 64;
		return int'(v);
	endfunction

	function automatic int cell_index(int w, int col, int row);
		return (row + 1) * (w + 2) + col + 1;
	endfunction

	function automatic int unsigned root_floor(int unsigned v);
		int unsigned r = 0;
		while ((r + 1) * (r + 1) <= v) r++;
		return r;
	endfunction

	// signed table scale of a height difference, weighted by the wave height
	function automatic logic [31:0] bend(logic [31:0] d, logic [31:0] wave);
		logic [31:0] mag, w, prod, r;
		mag = d[31] ? -d : d;
		if (mag > DEF_TABLE_LAST) mag = DEF_TABLE_LAST;
		w = $signed(wave + WAVE_BIAS) >>> WAVE_SHIFT;
		if (w[31]) w = '0;
		prod = shadow_table[mag] * w;
		r = $signed(prod) >>> REFR_SHIFT;
		return d[31] ? -r : r;
	endfunction

	function automatic ripple_result_t ripple_predict(logic [1:0] k,
			logic signed [15:0] dc, logic signed [15:0] dr, logic [5:0] qc,
			logic [5:0] qr, logic [IDX_W-1:0] ti, logic [31:0] tv);
		ripple_result_t res;
		int w, h, r, s, x, y, i, col, row;
		logic [31:0] val, sum, d, h0, h1, h2, bx, by;
		longint u, v;
		res = '{default: '0};
		w = eff_size(shadow_width);
		h = eff_size(shadow_height);
		case (k)
			KIND_DROP: begin
				r = int'(shadow_radius);
				s = (shadow_strength == 0) ? 1 : int'(shadow_strength);
				x = int'(dc);
				y = int'(dr);
				if (x < r) x = r;
				if (y < r) y = r;
				if (x >= w - r) x = w - r - 1;
				if (y >= h - r) y = h - r - 1;
				x = w - x;
				for (int b = 0; b < r; b++)
					for (int a = 0; a < r; a++)
						if (a * a + b * b < r * r) begin
							val = -(root_floor((r * r - a * a - b * b) << 16) / s);
							shadow_map[shadow_sel][cell_index(w, x + a, y - b)] = val;
							shadow_map[shadow_sel][cell_index(w, x + a, y + b)] = val;
							shadow_map[shadow_sel][cell_index(w, x - a, y - b)] = val;
							shadow_map[shadow_sel][cell_index(w, x - a, y + b)] = val;
						end
			end
			KIND_STEP: begin
				for (int rr = 0; rr < h; rr++)
					for (int cc = 0; cc < w; cc++) begin
						i = cell_index(w, cc, rr);
						sum = shadow_map[shadow_sel][i - (w + 2)] +
							shadow_map[shadow_sel][i + (w + 2)] +
							shadow_map[shadow_sel][i - 1] + shadow_map[shadow_sel][i + 1];
						d = ($signed(sum) >>> 1);
						d = d - shadow_map[!shadow_sel][i];
						d = d - 32'($signed(d) >>> 3);
						shadow_map[!shadow_sel][i] = d;
					end
				shadow_sel = !shadow_sel;
			end
			KIND_LOAD: begin
				if (ti <= DEF_TABLE_LAST) shadow_table[ti] = tv;
			end
			default: begin
				col = (qc >= w) ? w - 1 : int'(qc);
				row = (qr >= h) ? h - 1 : int'(qr);
				i = cell_index(w, col, row);
				h0 = shadow_map[shadow_sel][i];
				h1 = shadow_map[shadow_sel][i + 1];
				h2 = shadow_map[shadow_sel][i + w + 2];
				bx = $signed(bend(h1 - h0, h0)) >>> TEX_SHIFT;
				by = $signed(bend(h2 - h0, h0)) >>> TEX_SHIFT;
				u = longint'(col) + 1 + longint'($signed(bx));
				v = longint'(row) + 1 + longint'($signed(by));
				if (u < 0) u = 0;
				if (u >= w) u = w - 1;
				if (v < 0) v = 0;
				if (v >= h) v = h - 1;
				res.u = u[5:0];
				res.v = v[5:0];
				res.slope = h2 - h0;
				res.h = h0;
			end
		endcase
		return res;
	endfunction

	// one command transaction; inputs move on the falling edge
	task automatic issue_command(logic [1:0] k, int dc, int dr, int qc, int qr,
			int ti, int unsigned tv);
		logic signed [15:0] dc_v, dr_v;
		logic [5:0]         qc_v, qr_v;
		logic [IDX_W-1:0]   ti_v;
		logic [31:0]        tv_v;
		dc_v = 16'(dc);
		dr_v = 16'(dr);
		qc_v = 6'(qc);
		qr_v = 6'(qr);
		ti_v = IDX_W'(ti);
		tv_v = tv;
		if ($urandom_range(99) < idle_rate)
			repeat ($urandom_range(1, 6)) @(negedge clk);
		kind = k;
		drop_col = dc_v;
		drop_row = dr_v;
		cell_col = qc_v;
		cell_row = qr_v;
		table_index = ti_v;
		table_value = tv_v;
		start = 1'b1;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		pending_results.push_back(ripple_predict(k, dc_v, dr_v, qc_v, qr_v, ti_v, tv_v));
		@(negedge clk);
		start = 1'b0;
	endtask

	// random fill of the fields a command ignores keeps every input bit moving
	task automatic issue_kind(logic [1:0] k);
		issue_command(k, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic issue_drop(int c, int r);
		issue_command(KIND_DROP, c, r, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic issue_query(int c, int r);
		issue_command(KIND_QUERY, $urandom, $urandom, c, r, $urandom, $urandom);
	endtask

	// wait for the block to go quiet before touching registers
	task automatic drain;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		psel = 1'b1;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		case (idx)
			REG_MESH_WIDTH:    shadow_width = val[6:0];
			REG_MESH_HEIGHT:   shadow_height = val[6:0];
			REG_DROP_RADIUS:   shadow_radius = val[1:0];
			REG_DROP_STRENGTH: shadow_strength = val[7:0];
		endcase
	endtask

	task automatic set_mesh(int w, int h, int r, int s);
		drain();
		reg_write(REG_MESH_WIDTH, w);
		reg_write(REG_MESH_HEIGHT, h);
		reg_write(REG_DROP_RADIUS, r);
		reg_write(REG_DROP_STRENGTH, s);
	endtask

	// whole table, every query after this reads a loaded word
	task automatic test_table_load;
		for (int i = 0; i <= DEF_TABLE_LAST; i++)
			issue_command(KIND_LOAD, $urandom, $urandom, $urandom, $urandom, i,
				($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 600));
		// indexes past the end are dropped, then entries 1 and 2 get extreme values
		issue_command(KIND_LOAD, 0, 0, 0, 0, DEF_TABLE_LAST + 1, 32'h7fff_ffff);
		issue_command(KIND_LOAD, 0, 0, 0, 0, '1, 32'h8000_0000);
		issue_command(KIND_LOAD, 0, 0, 0, 0, 1, 32'h8000_0000);
		issue_command(KIND_LOAD, 0, 0, 0, 0, 2, 32'h7fff_ffff);
	endtask

	// extremes at full size, then saturation of the registers
	task automatic test_directed;
		issue_drop(-32768, -32768);
		issue_drop(32767, 32767);
		issue_drop(30, 30);
		issue_query(63, 63);
		issue_query(0, 0);
		issue_query(32, 29);
		issue_kind(KIND_STEP);
		issue_query(33, 30);
		// register extremes: sizes saturate, zero strength, widest disc
		set_mesh(0, 127, 3, 0);
		issue_drop(3, 3);
		issue_drop(-1, 40);
		issue_query(7, 63);
		issue_kind(KIND_STEP);
		issue_query(4, 4);
		set_mesh(8, 8, 0, 255);
		issue_drop(4, 4);
		issue_query(63, 0);
		set_mesh(9, 10, 1, 255);
		issue_drop(5, 5);
		issue_kind(KIND_STEP);
		issue_query(3, 5);
		issue_query(63, 63);
	endtask

	// random phases on small meshes, half of the commands drops and steps to build waves
	task automatic test_random;
		int sel;
		for (int phase = 0; phase < 6; phase++) begin
			set_mesh($urandom_range(8, 16), $urandom_range(8, 16), $urandom_range(1, 3),
				$urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(1, 4));
			// long stretch with no idling
			idle_rate = (phase == 2) ? 0 : 15;
			for (int n = 0; n < 20; n++) begin
				sel = $urandom_range(99);
				if (sel < 25)
					issue_drop(($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 18),
						($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 18));
				else if (sel < 50)
					issue_kind(KIND_STEP);
				else if (sel < 58)
					issue_command(KIND_LOAD, $urandom, $urandom, $urandom, $urandom,
						$urandom_range(0, 1023), $urandom_range(0, 600));
				else
					issue_query(($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 16),
						($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 16));
				// hold off until every result is home
				if (phase == 1 && n == 10)
					while (pending_results.size() != 0) @(negedge clk);
			end
		end
		idle_rate = 15;
	endtask

	initial begin
		foreach (shadow_map[m, i]) shadow_map[m][i] = '0;
		foreach (shadow_table[i]) shadow_table[i] = '0;
		shadow_sel = 1'b0;
		shadow_width = RST_MESH_WIDTH;
		shadow_height = RST_MESH_HEIGHT;
		shadow_radius = RST_DROP_RADIUS;
		shadow_strength = RST_DROP_STRENGTH;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		test_table_load();
		test_directed();
		test_random();
		drain();
		if (mismatch_count == 0)
			$display("water_ripple_heightfield_unit: match");
		else
			$display("water_ripple_heightfield_unit: mismatch");
		$finish;
	end

endmodule
